// ===== hw/rtl/irc_lt_pkg.sv =====
// Package: field widths, character codes, role/status/phase codes and result types.
package irc_lt_pkg;

    localparam int unsigned MAX_PARAMS = 15;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_role;
    typedef logic [3:0] t_pidx;
    typedef logic [1:0] t_status;
    typedef logic [3:0] t_pcount;
    typedef logic [2:0] t_phase;

    localparam t_role ROLE_SEP       = 3'd0;
    localparam t_role ROLE_PFX_COLON = 3'd1;
    localparam t_role ROLE_PREFIX    = 3'd2;
    localparam t_role ROLE_COMMAND   = 3'd3;
    localparam t_role ROLE_MIDDLE    = 3'd4;
    localparam t_role ROLE_TR_COLON  = 3'd5;
    localparam t_role ROLE_TRAILING  = 3'd6;
    localparam t_role ROLE_STRIPPED  = 3'd7;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_NO_CMD    = 2'd2;
    localparam t_status ST_EMPTY_CMD = 2'd3;

    localparam t_phase PH_START    = 3'd0;
    localparam t_phase PH_PREFIX   = 3'd1;
    localparam t_phase PH_AFTERPFX = 3'd2;
    localparam t_phase PH_COMMAND  = 3'd3;
    localparam t_phase PH_PARAMS   = 3'd4;
    localparam t_phase PH_MIDDLE   = 3'd5;
    localparam t_phase PH_TRAILING = 3'd6;

    typedef struct packed {
        t_byte   out_byte;
        t_role   role;
        t_pidx   param_index;
        logic    token_start;
        logic    line_end;
        t_status status;
        t_pcount param_count;
    } t_result;

    typedef struct packed {
        t_result res;
        t_phase  n_phase;
        t_pcount n_pc;
        logic    n_cmd;
    } t_cls;

endpackage

// ===== hw/rtl/irc_lt_if.sv =====
// Interfaces: raw byte input channel and tagged result output channel.
interface irc_lt_in_if;
    logic                valid;
    logic                ready;
    irc_lt_pkg::t_byte   in_byte;
    logic                last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface irc_lt_out_if;
    logic                 valid;
    logic                 ready;
    irc_lt_pkg::t_byte    out_byte;
    irc_lt_pkg::t_role    role;
    irc_lt_pkg::t_pidx    param_index;
    logic                 token_start;
    logic                 line_end;
    irc_lt_pkg::t_status  status;
    irc_lt_pkg::t_pcount  param_count;

    modport source (output valid, output out_byte, output role, output param_index,
                    output token_start, output line_end, output status,
                    output param_count, input ready);
    modport sink   (input valid, input out_byte, input role, input param_index,
                    input token_start, input line_end, input status,
                    input param_count, output ready);
endinterface

// ===== hw/rtl/irc_line_tokenizer.sv =====
// Top level: IRC line tokenizer, one byte per transaction, two-byte lookahead.
// Latency: a byte's result is registered in the cycle the byte two positions later is
// accepted; at line end, after last, the held bytes drain one per cycle while the skid entry is empty.
// Throughput: one byte per cycle inside a line while the skid entry is empty; input is
// blocked for the drain, set by the single shared classifier stepping over the held bytes.
// Reset (i_rst_n, synchronous, active low) clears line state and empties the output queue.
module irc_line_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irc_lt_in_if.sink     i_byte_if,
    irc_lt_out_if.source  o_tok_if
);

    irc_lt_pkg::t_byte   r_held [3];
    irc_lt_pkg::t_byte   n_held [3];
    logic [1:0]          r_count, n_count;
    logic [1:0]          r_keep, n_keep;
    logic                r_drain, n_drain;
    irc_lt_pkg::t_phase  r_phase, n_phase;
    irc_lt_pkg::t_pcount r_pc, n_pc;
    logic                r_cmd, n_cmd;

    irc_lt_pkg::t_result r_out, n_out;
    logic                r_out_valid, n_out_valid;
    irc_lt_pkg::t_result r_skid, n_skid;
    logic                r_skid_valid, n_skid_valid;

    irc_lt_pkg::t_cls    cls;
    irc_lt_pkg::t_result push_res;
    irc_lt_pkg::t_phase  fin_phase;
    logic                push;
    logic                pop;
    logic                in_fire;
    logic                drain_step;
    logic                is_lf;
    logic                is_cr;
    logic [1:0]          k_pre;

    function automatic irc_lt_pkg::t_pidx f_index(input irc_lt_pkg::t_pcount pc);
        irc_lt_pkg::t_pcount i;
        i = (pc == '0) ? '0 : pc - 4'd1;
        if (i > 4'(irc_lt_pkg::MAX_PARAMS - 1)) begin
            i = 4'(irc_lt_pkg::MAX_PARAMS - 1);
        end
        return i;
    endfunction

    function automatic logic f_is_ws(input irc_lt_pkg::t_byte c);
        return (c == irc_lt_pkg::CH_SPACE) || (c >= irc_lt_pkg::CH_TAB && c <= irc_lt_pkg::CH_CR);
    endfunction

    function automatic irc_lt_pkg::t_cls f_classify(
        input irc_lt_pkg::t_byte   c,
        input irc_lt_pkg::t_phase  ph,
        input irc_lt_pkg::t_pcount pc,
        input logic                cmd
    );
        irc_lt_pkg::t_cls    r;
        irc_lt_pkg::t_pcount npc;
        r = '0;
        r.n_phase = ph;
        r.n_pc = pc;
        r.n_cmd = cmd;
        r.res.out_byte = c;
        npc = (pc < 4'(irc_lt_pkg::MAX_PARAMS)) ? pc + 4'd1 : pc;
        unique case (ph)
            irc_lt_pkg::PH_START: begin
                if (c == irc_lt_pkg::CH_COLON) begin
                    r.res.role = irc_lt_pkg::ROLE_PFX_COLON;
                    r.res.token_start = 1'b1;
                    r.n_phase = irc_lt_pkg::PH_PREFIX;
                end else if (c == irc_lt_pkg::CH_SPACE) begin
                    r.res.role = irc_lt_pkg::ROLE_SEP;
                    r.n_cmd = 1'b0;
                    r.n_phase = irc_lt_pkg::PH_PARAMS;
                end else begin
                    r.res.role = irc_lt_pkg::ROLE_COMMAND;
                    r.res.token_start = 1'b1;
                    r.n_cmd = 1'b1;
                    r.n_phase = irc_lt_pkg::PH_COMMAND;
                end
            end
            irc_lt_pkg::PH_PREFIX: begin
                if (c == irc_lt_pkg::CH_SPACE) begin
                    r.res.role = irc_lt_pkg::ROLE_SEP;
                    r.n_phase = irc_lt_pkg::PH_AFTERPFX;
                end else begin
                    r.res.role = irc_lt_pkg::ROLE_PREFIX;
                end
            end
            irc_lt_pkg::PH_AFTERPFX: begin
                if (c == irc_lt_pkg::CH_SPACE) begin
                    r.res.role = irc_lt_pkg::ROLE_SEP;
                end else begin
                    r.res.role = irc_lt_pkg::ROLE_COMMAND;
                    r.res.token_start = 1'b1;
                    r.n_cmd = 1'b1;
                    r.n_phase = irc_lt_pkg::PH_COMMAND;
                end
            end
            irc_lt_pkg::PH_COMMAND: begin
                if (c == irc_lt_pkg::CH_SPACE) begin
                    r.res.role = irc_lt_pkg::ROLE_SEP;
                    r.n_phase = irc_lt_pkg::PH_PARAMS;
                end else begin
                    r.res.role = irc_lt_pkg::ROLE_COMMAND;
                end
            end
            irc_lt_pkg::PH_PARAMS: begin
                if (f_is_ws(c)) begin
                    r.res.role = irc_lt_pkg::ROLE_SEP;
                end else begin
                    r.n_pc = npc;
                    r.res.param_index = f_index(npc);
                    r.res.token_start = 1'b1;
                    if (c == irc_lt_pkg::CH_COLON) begin
                        r.res.role = irc_lt_pkg::ROLE_TR_COLON;
                        r.n_phase = irc_lt_pkg::PH_TRAILING;
                    end else begin
                        r.res.role = irc_lt_pkg::ROLE_MIDDLE;
                        r.n_phase = irc_lt_pkg::PH_MIDDLE;
                    end
                end
            end
            irc_lt_pkg::PH_MIDDLE: begin
                if (f_is_ws(c)) begin
                    r.res.role = irc_lt_pkg::ROLE_SEP;
                    r.n_phase = irc_lt_pkg::PH_PARAMS;
                end else begin
                    r.res.role = irc_lt_pkg::ROLE_MIDDLE;
                    r.res.param_index = f_index(pc);
                end
            end
            default: begin
                r.res.role = irc_lt_pkg::ROLE_TRAILING;
                r.res.param_index = f_index(pc);
            end
        endcase
        if (r.res.role == irc_lt_pkg::ROLE_COMMAND && c >= irc_lt_pkg::CH_LC_A
                && c <= irc_lt_pkg::CH_LC_Z) begin
            r.res.out_byte = c - irc_lt_pkg::CASE_OFS;
        end
        return r;
    endfunction

    assign in_fire    = i_byte_if.valid && i_byte_if.ready;
    assign drain_step = r_drain && !r_skid_valid;
    assign pop        = r_out_valid && o_tok_if.ready;
    assign cls        = f_classify(r_held[0], r_phase, r_pc, r_cmd);

    assign is_lf = (i_byte_if.in_byte == irc_lt_pkg::CH_LF);

    // Strip check: CR candidate is the byte before a final LF, else the final byte.
    always_comb begin
        is_cr = 1'b0;
        k_pre = r_count + 2'd1;
        if (is_lf) begin
            k_pre = r_count;
            case (r_count)
                2'd1:    is_cr = (r_held[0] == irc_lt_pkg::CH_CR);
                2'd2:    is_cr = (r_held[1] == irc_lt_pkg::CH_CR);
                default: is_cr = 1'b0;
            endcase
        end else begin
            is_cr = (i_byte_if.in_byte == irc_lt_pkg::CH_CR);
        end
    end

    always_comb begin
        n_held      = r_held;
        n_count     = r_count;
        n_keep      = r_keep;
        n_drain     = r_drain;
        n_phase     = r_phase;
        n_pc        = r_pc;
        n_cmd       = r_cmd;
        push        = 1'b0;
        push_res    = cls.res;
        fin_phase   = r_phase;

        if (in_fire) begin
            if (i_byte_if.last) begin
                if (r_count == 2'd0) begin
                    n_held[0] = i_byte_if.in_byte;
                end else if (r_count == 2'd1) begin
                    n_held[1] = i_byte_if.in_byte;
                end else begin
                    n_held[2] = i_byte_if.in_byte;
                end
                n_count = r_count + 2'd1;
                n_keep  = k_pre - {1'b0, is_cr};
                n_drain = 1'b1;
            end else if (r_count == 2'd2) begin
                push      = 1'b1;
                n_phase   = cls.n_phase;
                n_pc      = cls.n_pc;
                n_cmd     = cls.n_cmd;
                n_held[0] = r_held[1];
                n_held[1] = i_byte_if.in_byte;
            end else begin
                if (r_count == 2'd0) begin
                    n_held[0] = i_byte_if.in_byte;
                end else begin
                    n_held[1] = i_byte_if.in_byte;
                end
                n_count = r_count + 2'd1;
            end
        end else if (drain_step) begin
            push = 1'b1;
            if (r_keep != 2'd0) begin
                n_phase   = cls.n_phase;
                n_pc      = cls.n_pc;
                n_cmd     = cls.n_cmd;
                fin_phase = cls.n_phase;
                n_keep    = r_keep - 2'd1;
            end else begin
                push_res          = '0;
                push_res.out_byte = r_held[0];
                push_res.role     = irc_lt_pkg::ROLE_STRIPPED;
            end
            n_held[0] = r_held[1];
            n_held[1] = r_held[2];
            n_count   = r_count - 2'd1;
            if (r_count == 2'd1) begin
                push_res.line_end    = 1'b1;
                push_res.param_count = n_pc;
                if (fin_phase == irc_lt_pkg::PH_START) begin
                    push_res.status = irc_lt_pkg::ST_EMPTY;
                end else if (fin_phase == irc_lt_pkg::PH_PREFIX
                        || fin_phase == irc_lt_pkg::PH_AFTERPFX) begin
                    push_res.status = irc_lt_pkg::ST_NO_CMD;
                end else if (!n_cmd) begin
                    push_res.status = irc_lt_pkg::ST_EMPTY_CMD;
                end else begin
                    push_res.status = irc_lt_pkg::ST_OK;
                end
                n_phase = irc_lt_pkg::PH_START;
                n_pc    = '0;
                n_cmd   = 1'b0;
                n_count = 2'd0;
                n_keep  = 2'd0;
                n_drain = 1'b0;
            end
        end
    end

    // Output register with one skid entry.
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (pop && r_skid_valid) begin
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end else if (pop || !r_out_valid) begin
            n_out       = push_res;
            n_out_valid = push;
        end else if (push) begin
            n_skid       = push_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_out  <= n_out;
        r_skid <= n_skid;
        if (!i_rst_n) begin
            r_count      <= '0;
            r_keep       <= '0;
            r_drain      <= 1'b0;
            r_phase      <= irc_lt_pkg::PH_START;
            r_pc         <= '0;
            r_cmd        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_keep       <= n_keep;
            r_drain      <= n_drain;
            r_phase      <= n_phase;
            r_pc         <= n_pc;
            r_cmd        <= n_cmd;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign i_byte_if.ready = !r_skid_valid && !r_drain;

    assign o_tok_if.valid       = r_out_valid;
    assign o_tok_if.out_byte    = r_out.out_byte;
    assign o_tok_if.role        = r_out.role;
    assign o_tok_if.param_index = r_out.param_index;
    assign o_tok_if.token_start = r_out.token_start;
    assign o_tok_if.line_end    = r_out.line_end;
    assign o_tok_if.status      = r_out.status;
    assign o_tok_if.param_count = r_out.param_count;

endmodule

// ===== sim/testbench.sv =====
// Testbench for irc_line_tokenizer: directed and random IRC lines against a line predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned QUIET_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    irc_lt_in_if  byte_if ();
    irc_lt_out_if tok_if ();

    irc_line_tokenizer i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (byte_if),
        .o_tok_if  (tok_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned mismatches;
    int unsigned bytes_sent;

    irc_lt_pkg::t_result expected_tokens[$];
    irc_lt_pkg::t_byte   line_buf[$];

    // line parser state
    irc_lt_pkg::t_phase  lex_phase;
    irc_lt_pkg::t_byte   look[2];
    int unsigned         look_cnt;
    irc_lt_pkg::t_pcount params_seen;
    logic                cmd_seen;

    task automatic add_token(input irc_lt_pkg::t_result r);
        expected_tokens.insert(expected_tokens.size(), r);
    endtask

    task automatic add_byte(input irc_lt_pkg::t_byte b);
        line_buf.insert(line_buf.size(), b);
    endtask

    function automatic logic is_blank(input irc_lt_pkg::t_byte c);
        return c == irc_lt_pkg::CH_SPACE || (c >= irc_lt_pkg::CH_TAB && c <= irc_lt_pkg::CH_CR);
    endfunction

    function automatic irc_lt_pkg::t_pidx param_slot();
        if (params_seen == 0)
            return '0;
        if (params_seen - 1 > irc_lt_pkg::MAX_PARAMS - 1)
            return irc_lt_pkg::t_pidx'(irc_lt_pkg::MAX_PARAMS - 1);
        return irc_lt_pkg::t_pidx'(params_seen - 1);
    endfunction

    function automatic irc_lt_pkg::t_result classify_byte(input irc_lt_pkg::t_byte c);
        irc_lt_pkg::t_result r;
        r = '0;
        r.out_byte = c;
        r.role = irc_lt_pkg::ROLE_SEP;
        case (lex_phase)
            irc_lt_pkg::PH_START: begin
                if (c == irc_lt_pkg::CH_COLON) begin
                    r.role = irc_lt_pkg::ROLE_PFX_COLON;
                    r.token_start = 1'b1;
                    lex_phase = irc_lt_pkg::PH_PREFIX;
                end else if (c == irc_lt_pkg::CH_SPACE) begin
                    cmd_seen = 1'b0;
                    lex_phase = irc_lt_pkg::PH_PARAMS;
                end else begin
                    r.role = irc_lt_pkg::ROLE_COMMAND;
                    r.token_start = 1'b1;
                    cmd_seen = 1'b1;
                    lex_phase = irc_lt_pkg::PH_COMMAND;
                end
            end
            irc_lt_pkg::PH_PREFIX: begin
                if (c == irc_lt_pkg::CH_SPACE)
                    lex_phase = irc_lt_pkg::PH_AFTERPFX;
                else
                    r.role = irc_lt_pkg::ROLE_PREFIX;
            end
            irc_lt_pkg::PH_AFTERPFX: begin
                if (c != irc_lt_pkg::CH_SPACE) begin
                    r.role = irc_lt_pkg::ROLE_COMMAND;
                    r.token_start = 1'b1;
                    cmd_seen = 1'b1;
                    lex_phase = irc_lt_pkg::PH_COMMAND;
                end
            end
            irc_lt_pkg::PH_COMMAND: begin
                if (c == irc_lt_pkg::CH_SPACE)
                    lex_phase = irc_lt_pkg::PH_PARAMS;
                else
                    r.role = irc_lt_pkg::ROLE_COMMAND;
            end
            irc_lt_pkg::PH_PARAMS: begin
                if (!is_blank(c)) begin
                    if (params_seen < irc_lt_pkg::MAX_PARAMS)
                        params_seen++;
                    r.param_index = param_slot();
                    r.token_start = 1'b1;
                    if (c == irc_lt_pkg::CH_COLON) begin
                        r.role = irc_lt_pkg::ROLE_TR_COLON;
                        lex_phase = irc_lt_pkg::PH_TRAILING;
                    end else begin
                        r.role = irc_lt_pkg::ROLE_MIDDLE;
                        lex_phase = irc_lt_pkg::PH_MIDDLE;
                    end
                end
            end
            irc_lt_pkg::PH_MIDDLE: begin
                if (is_blank(c)) begin
                    lex_phase = irc_lt_pkg::PH_PARAMS;
                end else begin
                    r.role = irc_lt_pkg::ROLE_MIDDLE;
                    r.param_index = param_slot();
                end
            end
            default: begin
                r.role = irc_lt_pkg::ROLE_TRAILING;
                r.param_index = param_slot();
            end
        endcase
        if (r.role == irc_lt_pkg::ROLE_COMMAND && c >= irc_lt_pkg::CH_LC_A
                && c <= irc_lt_pkg::CH_LC_Z)
            r.out_byte = c - irc_lt_pkg::CASE_OFS;
        return r;
    endfunction

    task automatic clear_line();
        lex_phase   = irc_lt_pkg::PH_START;
        look_cnt    = 0;
        params_seen = '0;
        cmd_seen    = 1'b0;
    endtask

    task automatic predict_byte(input irc_lt_pkg::t_byte c, input logic lst);
        irc_lt_pkg::t_byte   seq[3];
        irc_lt_pkg::t_result res[3];
        int                  n;
        int                  k;
        if (!lst) begin
            if (look_cnt < 2) begin
                look[look_cnt] = c;
                look_cnt++;
            end else begin
                add_token(classify_byte(look[0]));
                look[0] = look[1];
                look[1] = c;
            end
        end else begin
            for (int i = 0; i < look_cnt; i++)
                seq[i] = look[i];
            seq[look_cnt] = c;
            n = look_cnt + 1;
            k = n;
            if (seq[k-1] == irc_lt_pkg::CH_LF)
                k--;
            if (k > 0 && seq[k-1] == irc_lt_pkg::CH_CR)
                k--;
            for (int i = 0; i < n; i++) begin
                if (i < k) begin
                    res[i] = classify_byte(seq[i]);
                end else begin
                    res[i] = '0;
                    res[i].out_byte = seq[i];
                    res[i].role = irc_lt_pkg::ROLE_STRIPPED;
                end
            end
            res[n-1].line_end = 1'b1;
            if (lex_phase == irc_lt_pkg::PH_START)
                res[n-1].status = irc_lt_pkg::ST_EMPTY;
            else if (lex_phase == irc_lt_pkg::PH_PREFIX || lex_phase == irc_lt_pkg::PH_AFTERPFX)
                res[n-1].status = irc_lt_pkg::ST_NO_CMD;
            else if (!cmd_seen)
                res[n-1].status = irc_lt_pkg::ST_EMPTY_CMD;
            else
                res[n-1].status = irc_lt_pkg::ST_OK;
            res[n-1].param_count = params_seen;
            for (int i = 0; i < n; i++)
                add_token(res[i]);
            clear_line();
        end
    endtask

    task automatic send_byte(input irc_lt_pkg::t_byte b, input logic lst);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_if.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid   = 1'b1;
        byte_if.in_byte = b;
        byte_if.last    = lst;
        @(posedge i_clk);
        while (!byte_if.ready)
            @(posedge i_clk);
        predict_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(irc_lt_pkg::t_byte'(s[i]));
        send_line();
    endtask

    // hold the sender until every pending token is out
    task automatic drain_results();
        @(negedge i_clk);
        byte_if.valid = 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic irc_lt_pkg::t_byte word_byte();
        irc_lt_pkg::t_byte c;
        do c = irc_lt_pkg::t_byte'($urandom_range(255)); while (is_blank(c));
        return c;
    endfunction

    function automatic irc_lt_pkg::t_byte head_byte();
        irc_lt_pkg::t_byte c;
        do c = word_byte(); while (c == irc_lt_pkg::CH_COLON);
        return c;
    endfunction

    function automatic irc_lt_pkg::t_byte blank_byte();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 0) ? irc_lt_pkg::CH_SPACE : irc_lt_pkg::t_byte'(irc_lt_pkg::CH_TAB + k - 1);
    endfunction

    function automatic irc_lt_pkg::t_byte cmd_byte();
        case ($urandom_range(3))
            0: return irc_lt_pkg::t_byte'(irc_lt_pkg::CH_LC_A + $urandom_range(25));
            1: return irc_lt_pkg::t_byte'(irc_lt_pkg::CH_LC_A - irc_lt_pkg::CASE_OFS
                                          + $urandom_range(25));
            2: return irc_lt_pkg::t_byte'(8'h30 + $urandom_range(9));
            default: return head_byte();
        endcase
    endfunction

    task automatic build_random_line(input bit wide);
        int unsigned kind;
        int unsigned n_params;
        int unsigned cut;
        kind = $urandom_range(99);
        if (!wide && kind < 12) begin
            repeat ($urandom_range(1, 10))
                add_byte(irc_lt_pkg::t_byte'($urandom_range(255)));
            return;
        end
        if ($urandom_range(2) == 0) begin
            add_byte(irc_lt_pkg::CH_COLON);
            repeat ($urandom_range(0, 4))
                add_byte(head_byte());
            add_byte(irc_lt_pkg::CH_SPACE);
            if ($urandom_range(3) == 0)
                add_byte(irc_lt_pkg::CH_SPACE);
        end
        if ($urandom_range(9) == 0)
            add_byte(irc_lt_pkg::CH_SPACE);
        else
            repeat ($urandom_range(1, 4))
                add_byte(cmd_byte());
        n_params = wide ? $urandom_range(15, 18) : $urandom_range(0, 4);
        repeat (n_params) begin
            add_byte(irc_lt_pkg::CH_SPACE);
            if ($urandom_range(4) == 0)
                add_byte(blank_byte());
            add_byte(head_byte());
            if (!wide)
                repeat ($urandom_range(0, 3))
                    add_byte(word_byte());
        end
        if ($urandom_range(2) == 0) begin
            add_byte(irc_lt_pkg::CH_SPACE);
            add_byte(irc_lt_pkg::CH_COLON);
            repeat ($urandom_range(0, 6))
                add_byte(irc_lt_pkg::t_byte'($urandom_range(255)));
        end
        case ($urandom_range(3))
            1: begin
                add_byte(irc_lt_pkg::CH_CR);
                add_byte(irc_lt_pkg::CH_LF);
            end
            2: add_byte(irc_lt_pkg::CH_LF);
            3: add_byte(irc_lt_pkg::CH_CR);
            default: ;
        endcase
        // break the line short
        if (!wide && kind < 22) begin
            cut = $urandom_range(1, line_buf.size());
            while (line_buf.size() > cut)
                void'(line_buf.pop_back());
        end
    endtask

    task automatic test_line_edges();
        send_text("\012");
        send_text("\015\012");
        send_text(":a");
        send_text(": z");
        send_text(" b");
    endtask

    task automatic test_token_roles();
        send_text("ab :c d\015\012");
        add_byte(8'hFF);
        add_byte(8'h00);
        send_line();
        send_text("X y\011z\014");
    endtask

    task automatic test_random_lines(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned n_bytes);
        int unsigned start;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start = bytes_sent;
        build_random_line(1'b1);
        send_line();
        while (bytes_sent - start < n_bytes) begin
            build_random_line(1'b0);
            send_line();
        end
        drain_results();
    endtask

    initial begin
        tok_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tok_if.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        irc_lt_pkg::t_result got;
        irc_lt_pkg::t_result want;
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            got.out_byte    = tok_if.out_byte;
            got.role        = tok_if.role;
            got.param_index = tok_if.param_index;
            got.token_start = tok_if.token_start;
            got.line_end    = tok_if.line_end;
            got.status      = tok_if.status;
            got.param_count = tok_if.param_count;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token byte=%h role=%0d", $time,
                         got.out_byte, got.role);
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    $display("%0t: token mismatch exp byte=%h role=%0d idx=%0d start=%b",
                             $time, want.out_byte, want.role, want.param_index,
                             want.token_start, " end=%b st=%0d cnt=%0d", want.line_end,
                             want.status, want.param_count);
                    $display("%0t:                got byte=%h role=%0d idx=%0d start=%b",
                             $time, got.out_byte, got.role, got.param_index,
                             got.token_start, " end=%b st=%0d cnt=%0d", got.line_end,
                             got.status, got.param_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid && byte_if.ready) || (tok_if.valid && tok_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = '0;
        byte_if.last    = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        mismatches      = 0;
        bytes_sent      = 0;
        clear_line();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_line_edges();
        test_token_roles();
        drain_results();
        test_random_lines(0, 0, 55);
        test_random_lines(62, 0, 55);
        test_random_lines(0, 62, 55);
        test_random_lines(36, 36, 55);

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
